// ----- rtl/hmap_pkg.sv -----
// Shared types and constants for the bucketed hash map.
// No dependencies; imported by every module of the block.
package hmap_pkg;

    localparam int KEY_W  = 64;
    localparam int VAL_W  = 64;
    localparam int DIV_W  = 11;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] ST_PRESENT = 2'd0;
    localparam logic [STAT_W-1:0] ST_ABSENT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_PUT    = 1'b1;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

endpackage

// ----- rtl/bucketed_hash_map.sv -----
// Top level of the bucketed hash map: control sequencer, way compare, result register.
// Depends on hmap_pkg, hmap_div and hmap_mem.
//
// Usage:
//   Request channel: drive i_func, i_key, i_value and raise start; the request is
//   taken at a rising edge with start high and busy low. i_func 0 looks up i_key,
//   i_func 1 stores i_value under i_key (update if present, else fill the lowest
//   free way of the bucket, else report bucket full and drop).
//   Result channel: o_strobe is high for one cycle with o_status and
//   o_found_value; the receiver cannot stall it.
//   Config channel: i_cfg_valid / o_cfg_ready carry the bucket count (11 bits);
//   0 acts as 1, values above BUCKETS act as BUCKETS. Write it only while idle.
// Operation:
//   The bucket is the key modulo the bucket count, computed by a bit-serial
//   remainder unit; then the bucket row is read into a register, and in the
//   compare state the ways are compared, the row is written back and the
//   result is registered together with o_strobe. busy drops with the strobe,
//   so a new request is taken only once the previous result is out.
//   Reset: a clearing pass writes every bucket row empty with busy high;
//   configuration writes are taken during it.
module bucketed_hash_map #(
    parameter int BUCKETS = 1024,
    parameter int WAYS    = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_func,
    input  logic [hmap_pkg::KEY_W-1:0]  i_key,
    input  logic [hmap_pkg::VAL_W-1:0]  i_value,
    output logic                        o_strobe,
    output logic [hmap_pkg::STAT_W-1:0] o_status,
    output logic [hmap_pkg::VAL_W-1:0]  o_found_value,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [hmap_pkg::DIV_W-1:0]  i_cfg_data
);
    import hmap_pkg::*;

    localparam int AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_CMP
    } t_state;

    t_state             r_state;
    logic [AW-1:0]      r_clr_addr;
    logic [DIV_W-1:0]   r_bucket_count;
    logic               r_func;
    logic [KEY_W-1:0]   r_key;
    logic [VAL_W-1:0]   r_value;
    logic [AW-1:0]      r_bucket;
    logic               r_strobe;
    logic [STAT_W-1:0]  r_status;
    logic [VAL_W-1:0]   r_found;

    logic               div_start;
    logic               div_done;
    logic [DIV_W-1:0]   div_rem;
    logic [DIV_W-1:0]   divisor;
    logic [AW+DIV_W-1:0] rem_ext;
    logic [AW-1:0]      rem_addr;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    t_entry [WAYS-1:0]  mem_wdata;
    t_entry [WAYS-1:0]  mem_rdata;

    logic               hit;
    logic [VAL_W-1:0]   hit_value;
    logic               have_free;
    t_entry [WAYS-1:0]  n_row;
    logic               row_we;
    logic [STAT_W-1:0]  n_status;
    logic [VAL_W-1:0]   n_found;

    // clamp the configured count to 1..BUCKETS
    always_comb begin
        divisor = r_bucket_count;
        if (r_bucket_count == '0) begin
            divisor = DIV_W'(1);
        end else if (32'(r_bucket_count) > BUCKETS) begin
            divisor = DIV_W'(BUCKETS);
        end
    end

    assign div_start = (r_state == S_IDLE) && start;
    assign rem_ext   = {{AW{1'b0}}, div_rem};
    assign rem_addr  = rem_ext[AW-1:0];

    hmap_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_key),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // scan the ways: lowest matching valid entry, lowest free way
    always_comb begin
        hit       = 1'b0;
        hit_value = '0;
        have_free = 1'b0;
        n_row     = mem_rdata;
        row_we    = 1'b0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (!mem_rdata[w].valid) begin
                have_free = 1'b1;
            end
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (mem_rdata[w].valid && (mem_rdata[w].key == r_key)) begin
                hit       = 1'b1;
                hit_value = mem_rdata[w].value;
            end
        end
        if (r_func == FUNC_PUT) begin
            if (hit) begin
                for (int w = 0; w < WAYS; w++) begin
                    if (mem_rdata[w].valid && (mem_rdata[w].key == r_key)) begin
                        n_row[w].value = r_value;
                    end
                end
                row_we = 1'b1;
            end else if (have_free) begin
                // fill only the lowest free way
                for (int w = WAYS - 1; w >= 0; w--) begin
                    if (!mem_rdata[w].valid) begin
                        n_row    = mem_rdata;
                        n_row[w] = '{valid: 1'b1, key: r_key, value: r_value};
                    end
                end
                row_we = 1'b1;
            end
        end
        if (hit) begin
            n_status = ST_PRESENT;
        end else if ((r_func == FUNC_PUT) && !have_free) begin
            n_status = ST_FULL;
        end else begin
            n_status = ST_ABSENT;
        end
        n_found = (hit && (r_func == FUNC_LOOKUP)) ? hit_value : '0;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_bucket;
        mem_wdata = n_row;
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (r_state == S_CMP) begin
            mem_we = row_we;
        end
    end

    hmap_mem #(
        .ROWS (BUCKETS),
        .WAYS (WAYS),
        .AW   (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    ((r_state == S_DIV) && div_done),
        .i_raddr (rem_addr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr_addr     <= '0;
            r_bucket_count <= DIV_W'(1024);
            r_strobe       <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_bucket_count <= i_cfg_data;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_func  <= i_func;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if ((r_state == S_DIV) && div_done) begin
            r_bucket <= rem_addr;
        end
        if (r_state == S_CMP) begin
            r_status <= n_status;
            r_found  <= n_found;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_found_value = r_found;

    a_strobe_after_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_CMP))
        else $error("result strobe without a compare cycle");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_status == ST_PRESENT || o_status == ST_ABSENT
                      || o_status == ST_FULL))
        else $error("undefined status code");

    a_zero_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_PRESENT) |-> (o_found_value == '0))
        else $error("nonzero value without a hit");

    a_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_CLEAR || r_state == S_CMP))
        else $error("bucket write outside clear or compare");

endmodule

// ----- rtl/hmap_div.sv -----
// Bit-serial remainder unit: 64-bit key modulo an 11-bit bucket count.
// Depends on hmap_pkg; one quotient bit per cycle, done pulses after the last step.
module hmap_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [hmap_pkg::KEY_W-1:0] i_dividend,
    input  logic [hmap_pkg::DIV_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [hmap_pkg::DIV_W-1:0] o_rem
);
    import hmap_pkg::*;

    localparam int CNT_W = $clog2(KEY_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [KEY_W-1:0] r_dvd;
    logic [DIV_W-1:0] r_div;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] n_rem;
    logic [DIV_W:0]   trial;

    // shift in the next dividend bit, subtract the divisor when it fits
    always_comb begin
        trial = {r_rem, r_dvd[KEY_W-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = DIV_W'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(KEY_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[KEY_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- rtl/hmap_mem.sv -----
// Bucket memory: one row per bucket, WAYS entries of valid, key and value.
// Depends on hmap_pkg; one write port, one read port, registered read data.
module hmap_mem #(
    parameter int ROWS = 1024,
    parameter int WAYS = 4,
    parameter int AW   = 10
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [AW-1:0]                  i_waddr,
    input  hmap_pkg::t_entry [WAYS-1:0]    i_wdata,
    input  logic                           i_re,
    input  logic [AW-1:0]                  i_raddr,
    output hmap_pkg::t_entry [WAYS-1:0]    o_rdata
);
    import hmap_pkg::*;

    t_entry [WAYS-1:0] mem [0:ROWS-1];
    t_entry [WAYS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- bench/bucketed_hash_map_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for bucketed_hash_map: lookups and puts against a shadow table.
// Depends on hmap_pkg and the bucketed_hash_map RTL.
module bucketed_hash_map_tb;
    import hmap_pkg::*;

    localparam int BUCKETS     = 1024;
    localparam int WAYS        = 4;
    localparam int SLOTS       = BUCKETS * WAYS;
    localparam int PHASE_ITEMS = 154;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic             func;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_map_req;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  found_value;
    } t_map_rsp;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_func = FUNC_LOOKUP;
    logic [KEY_W-1:0]  i_key = '0;
    logic [VAL_W-1:0]  i_value = '0;
    logic              o_strobe;
    logic [STAT_W-1:0] o_status;
    logic [VAL_W-1:0]  o_found_value;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [DIV_W-1:0]  i_cfg_data = '0;

    t_map_req         request_q[$];
    t_map_rsp         pending_results[$];
    logic [KEY_W-1:0] key_pool[$];

    // shadow copy of the table and the bucket count register
    logic [KEY_W-1:0] shadow_key[SLOTS];
    logic [VAL_W-1:0] shadow_val[SLOTS];
    bit               shadow_used[SLOTS];
    logic [DIV_W-1:0] shadow_bkts = 11'd1024;

    bit          req_taken = 1'b0;
    bit          calm = 1'b0;
    int unsigned gap_left = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    bucketed_hash_map #(
        .BUCKETS(BUCKETS),
        .WAYS   (WAYS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_found_value(o_found_value),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int unsigned active_buckets(input logic [DIV_W-1:0] cnt);
        int unsigned n;
        n = cnt;
        if (n == 0) n = 1;
        if (n > BUCKETS) n = BUCKETS;
        return n;
    endfunction

    // Scan the key's bucket; on a match return (lookup) or update (put), else a put fills the lowest free way.
    function automatic t_map_rsp map_access(input logic fn, input logic [KEY_W-1:0] k,
                                            input logic [VAL_W-1:0] v);
        t_map_rsp    rsp;
        int unsigned base;
        int unsigned slot;
        int unsigned free_slot;
        bit          have_free;
        bit          hit;
        rsp.status      = ST_ABSENT;
        rsp.found_value = '0;
        base      = int'(k % 64'(active_buckets(shadow_bkts))) * WAYS;
        free_slot = 0;
        have_free = 1'b0;
        hit       = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            slot = base + w;
            if (!hit) begin
                if (shadow_used[slot]) begin
                    if (shadow_key[slot] == k) begin
                        hit        = 1'b1;
                        rsp.status = ST_PRESENT;
                        if (fn == FUNC_LOOKUP) rsp.found_value = shadow_val[slot];
                        else shadow_val[slot] = v;
                    end
                end else if (!have_free) begin
                    have_free = 1'b1;
                    free_slot = slot;
                end
            end
        end
        if (!hit && fn == FUNC_PUT) begin
            if (have_free) begin
                shadow_key[free_slot]  = k;
                shadow_val[free_slot]  = v;
                shadow_used[free_slot] = 1'b1;
            end else begin
                rsp.status = ST_FULL;
            end
        end
        return rsp;
    endfunction

    function automatic void report_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction

    // Mix reused keys, keys crowded into a few buckets, extremes and random keys.
    function automatic logic [KEY_W-1:0] pick_key(input int unsigned n);
        logic [KEY_W-1:0] k;
        int unsigned      roll;
        roll = $urandom_range(99);
        k    = {$urandom, $urandom};
        if (roll < 40 && key_pool.size() > 0) begin
            k = key_pool[$urandom_range(key_pool.size() - 1)];
        end else if (roll < 75) begin
            k = k - (k % 64'(n)) + 64'($urandom_range((n < 6) ? n - 1 : 5));
        end else if (roll < 80) begin
            k = roll[0] ? '0 : '1;
        end
        if (key_pool.size() < 48) key_pool.push_back(k);
        else key_pool[$urandom_range(47)] = k;
        return k;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10) return '0;
        if (roll < 20) return '1;
        return {$urandom, $urandom};
    endfunction

    task automatic add_request(input logic fn, input logic [KEY_W-1:0] k,
                               input logic [VAL_W-1:0] v);
        t_map_req req;
        req.func  = fn;
        req.key   = k;
        req.value = v;
        request_q.push_back(req);
    endtask

    task automatic wait_drained();
        while (request_q.size() != 0 || pending_results.size() != 0 || start)
            @(posedge i_clk);
    endtask

    task automatic write_bucket_count(input logic [DIV_W-1:0] cnt);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cnt;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= ~cnt;
    endtask

    // Driver: present the next request at the falling edge, hold it until taken.
    always @(negedge i_clk) begin
        t_map_req    req;
        int unsigned roll;
        roll = $urandom_range(99);
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !req_taken) begin
            // hold the request
        end else if (request_q.size() == 0 || gap_left != 0 || (!calm && roll < 29)) begin
            if (gap_left != 0) gap_left--;
            else if (!calm && roll < 3) gap_left = $urandom_range(1, 80);
            start   <= 1'b0;
            i_func  <= logic'($urandom_range(1));
            i_key   <= {$urandom, $urandom};
            i_value <= {$urandom, $urandom};
        end else begin
            req = request_q.pop_front();
            start   <= 1'b1;
            i_func  <= req.func;
            i_key   <= req.key;
            i_value <= req.value;
        end
    end

    // Monitor: check results, track register writes, predict accepted requests.
    always @(posedge i_clk) begin
        t_map_rsp want;
        req_taken = 1'b0;
        if (!i_rst_n) begin
            shadow_used = '{default: 1'b0};
            shadow_bkts = 11'd1024;
            pending_results.delete();
        end else begin
            if (o_strobe) begin
                if (pending_results.size() == 0) begin
                    report_error($sformatf("unexpected result status %0d value %h",
                                           o_status, o_found_value));
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status)
                        report_error($sformatf("status expected %0d actual %0d",
                                               want.status, o_status));
                    if (o_found_value !== want.found_value)
                        report_error($sformatf("found_value expected %h actual %h",
                                               want.found_value, o_found_value));
                end
            end
            if (i_cfg_valid && o_cfg_ready) shadow_bkts = i_cfg_data;
            if (start && !busy) begin
                pending_results.push_back(map_access(i_func, i_key, i_value));
                req_taken = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        logic [DIV_W-1:0] settings[8];
        int unsigned      n;
        settings = '{11'd0, 11'd2047, 11'd1, 11'd3, 11'd1025, 11'd1000, 11'd0, 11'd1024};
        settings[6] = 11'($urandom_range(2, 1023));

        // directed: empty table, extremes, update, a full bucket at reset count
        add_request(FUNC_LOOKUP, 64'd0, '1);
        add_request(FUNC_PUT, 64'd0, '1);
        add_request(FUNC_LOOKUP, 64'd0, '0);
        add_request(FUNC_PUT, 64'd0, '0);
        add_request(FUNC_LOOKUP, 64'd0, '1);
        add_request(FUNC_PUT, '1, 64'h5555_5555_5555_5555);
        add_request(FUNC_LOOKUP, '1, '0);
        for (int i = 0; i < 5; i++)
            add_request(FUNC_PUT, 64'(5 + 1024 * i), 64'(100 + i));
        add_request(FUNC_LOOKUP, 64'd4101, '0);
        add_request(FUNC_PUT, 64'd1029, 64'hAAAA_AAAA_AAAA_AAAA);
        add_request(FUNC_LOOKUP, 64'd1029, '0);
        add_request(FUNC_LOOKUP, 64'h8000_0000_0000_0005, '0);
        add_request(FUNC_PUT, 64'd0, '1);
        add_request(FUNC_LOOKUP, 64'd5, '0);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        // change the bucket count between phases; stale entries stay put
        foreach (settings[p]) begin
            write_bucket_count(settings[p]);
            n    = active_buckets(settings[p]);
            calm = (p == 4);
            for (int i = 0; i < PHASE_ITEMS; i++)
                add_request(logic'($urandom_range(1)), pick_key(n), pick_value());
            wait_drained();
        end

        repeat (100) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/hmap_pkg.sv
rtl/hmap_div.sv
rtl/hmap_mem.sv
rtl/bucketed_hash_map.sv
bench/bucketed_hash_map_tb.sv
